// ===== hdl/bls_pkg.sv =====
// bls_pkg: shared types and constants for the bicolor led sequencer
// no dependencies; used by bicolor_led_sequencer, bls_checker, bls_scoreboard and tb_top
`default_nettype none

package bls_pkg;

	localparam int TIMER_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIMER_W-1:0] TIMER_MAX    = 16'hFFFF;
	localparam logic [TIMER_W-1:0] GLOW_ENDLESS = 16'hFFFF;

	localparam logic [CFG_W-1:0] CYCLE_PERIOD_RESET = 16'd500;
	localparam logic [CFG_W-1:0] BLINK_HALF_RESET   = 16'd300;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 1'd1;

	// operating modes
	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_STARTUP = 2'd1;
	localparam logic [1:0] MODE_SHOW    = 2'd2;

	// color codes
	localparam logic [1:0] COLOR_RED    = 2'd0;
	localparam logic [1:0] COLOR_YELLOW = 2'd1;
	localparam logic [1:0] COLOR_GREEN  = 2'd2;
	localparam logic [1:0] COLOR_NONE   = 2'd3;

	// startup show steps
	localparam logic [1:0] STEP_RED    = 2'd1;
	localparam logic [1:0] STEP_YELLOW = 2'd2;
	localparam logic [1:0] STEP_GREEN  = 2'd3;

	typedef struct packed {
		logic               startup_run;
		logic               startup_complete;
		logic               show_request;
		logic               turn_off;
		logic [1:0]         req_color;
		logic               req_blink;
		logic [TIMER_W-1:0] req_glow_ms;
	} item_t;

	typedef struct packed {
		logic       red_on;
		logic       green_on;
		logic [1:0] mode_now;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/bicolor_led_sequencer.sv =====
// bicolor_led_sequencer: top level, tick-driven red/green led sequencer
// depends on bls_pkg
`default_nettype none

// Each accepted word is one millisecond tick with its event flags; the block
// returns one result word per tick holding both led levels and the mode. All
// state updates for a tick happen together: a word is accepted every cycle unless
// item_stall is high, and its result appears in the result register on the next
// cycle. The result register alone decides backpressure: item_stall is high only
// while a result is held and the receiver stalls it. The user must write configuration
// registers via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module bicolor_led_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output      logic                          item_stall,
	input  wire bls_pkg::item_t                item,
	output      logic                          result_valid,
	input  wire logic                          result_stall,
	output      bls_pkg::result_t              result,
	input  wire logic                          cfg_we,
	input  wire logic [bls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bls_pkg::CFG_W-1:0]     cfg_data
);

	logic [bls_pkg::CFG_W-1:0] cycle_period_q;
	logic [bls_pkg::CFG_W-1:0] blink_half_q;

	logic [1:0]                  mode_q, mode_d;
	logic [1:0]                  step_q, step_d;
	logic [bls_pkg::TIMER_W-1:0] show_timer_q, show_timer_d;
	logic [bls_pkg::TIMER_W-1:0] blink_timer_q, blink_timer_d;
	logic [1:0]                  held_color_q, held_color_d;
	logic                        held_blink_q, held_blink_d;
	logic [bls_pkg::TIMER_W-1:0] held_glow_q, held_glow_d;
	logic                        phase_lit_q, phase_lit_d;
	logic                        red_q, red_d;
	logic                        green_q, green_d;

	logic                        result_valid_q;
	bls_pkg::result_t            result_q;
	logic                        accept;

	assign item_stall   = result_valid_q & result_stall;
	assign accept       = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_period_q <= bls_pkg::CYCLE_PERIOD_RESET;
			blink_half_q   <= bls_pkg::BLINK_HALF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bls_pkg::CFG_CYCLE_PERIOD: cycle_period_q <= cfg_data;
				bls_pkg::CFG_BLINK_HALF:   blink_half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		// timers advance first, then the mode logic works on the new values
		show_timer_d  = (show_timer_q == bls_pkg::TIMER_MAX) ? show_timer_q
		                                                     : show_timer_q + 1'b1;
		blink_timer_d = (blink_timer_q == bls_pkg::TIMER_MAX) ? blink_timer_q
		                                                      : blink_timer_q + 1'b1;
		mode_d       = mode_q;
		step_d       = step_q;
		held_color_d = held_color_q;
		held_blink_d = held_blink_q;
		held_glow_d  = held_glow_q;
		phase_lit_d  = phase_lit_q;
		red_d        = red_q;
		green_d      = green_q;

		unique case (mode_q)
			bls_pkg::MODE_STARTUP: begin
				if (item.startup_complete) begin
					mode_d  = bls_pkg::MODE_IDLE;
					red_d   = 1'b0;
					green_d = 1'b0;
				end else if (show_timer_d >= cycle_period_q) begin
					step_d = (step_q == bls_pkg::STEP_GREEN) ? bls_pkg::STEP_RED
					                                         : step_q + 1'b1;
					red_d   = (step_d != bls_pkg::STEP_GREEN);
					green_d = (step_d != bls_pkg::STEP_RED);
					show_timer_d = '0;
				end
			end
			bls_pkg::MODE_SHOW: begin
				if (item.turn_off || (held_glow_q != bls_pkg::GLOW_ENDLESS &&
				                      show_timer_d >= held_glow_q)) begin
					mode_d  = bls_pkg::MODE_IDLE;
					red_d   = 1'b0;
					green_d = 1'b0;
				end else begin
					if (phase_lit_q) begin
						case (held_color_q)
							bls_pkg::COLOR_RED:    begin red_d = 1'b1; green_d = 1'b0; end
							bls_pkg::COLOR_YELLOW: begin red_d = 1'b1; green_d = 1'b1; end
							bls_pkg::COLOR_GREEN:  begin red_d = 1'b0; green_d = 1'b1; end
							default: ;  // color none keeps the leds
						endcase
					end else begin
						red_d   = 1'b0;
						green_d = 1'b0;
					end
					if (held_blink_q && blink_timer_d >= blink_half_q) begin
						phase_lit_d   = ~phase_lit_q;
						blink_timer_d = '0;
					end
				end
			end
			default: begin
				if (item.startup_run) begin
					mode_d       = bls_pkg::MODE_STARTUP;
					show_timer_d = '0;
				end else if (item.show_request) begin
					held_color_d  = item.req_color;
					held_blink_d  = item.req_blink;
					held_glow_d   = item.req_glow_ms;
					phase_lit_d   = 1'b1;
					mode_d        = bls_pkg::MODE_SHOW;
					show_timer_d  = '0;
					blink_timer_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= bls_pkg::MODE_IDLE;
			step_q        <= '0;
			show_timer_q  <= '0;
			blink_timer_q <= '0;
			held_color_q  <= '0;
			held_blink_q  <= 1'b0;
			held_glow_q   <= '0;
			phase_lit_q   <= 1'b0;
			red_q         <= 1'b0;
			green_q       <= 1'b0;
		end else if (accept) begin
			mode_q        <= mode_d;
			step_q        <= step_d;
			show_timer_q  <= show_timer_d;
			blink_timer_q <= blink_timer_d;
			held_color_q  <= held_color_d;
			held_blink_q  <= held_blink_d;
			held_glow_q   <= held_glow_d;
			phase_lit_q   <= phase_lit_d;
			red_q         <= red_d;
			green_q       <= green_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.red_on   <= red_d;
			result_q.green_on <= green_d;
			result_q.mode_now <= mode_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bls_checker.sv =====
// bls_checker: port-level assertions for bicolor_led_sequencer, with bind
// depends on bls_pkg and bicolor_led_sequencer
`default_nettype none

module bls_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire bls_pkg::result_t result
);

	// a held result word stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// the input side only stalls behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a blocked result");

	// every accepted tick yields a result word next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> result_valid)
		else $error("accepted word gave no result");

	// idle always shows both leds dark
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mode_now == bls_pkg::MODE_IDLE
		|-> !result.red_on && !result.green_on)
		else $error("leds lit while idle");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.mode_now <= bls_pkg::MODE_SHOW)
		else $error("unused mode code on result");

endmodule

bind bicolor_led_sequencer bls_checker u_bls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// ===== verif/bls_checker.sv =====
`timescale 1ns / 100ps
// bls_scoreboard: tracks the led sequencer state per accepted tick word and compares
// every result word against its own prediction; depends on bls_pkg
module bls_scoreboard (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	input  wire logic                          item_stall,
	input  wire bls_pkg::item_t                item,
	input  wire logic                          result_valid,
	input  wire logic                          result_stall,
	input  wire bls_pkg::result_t              result,
	input  wire logic                          cfg_we,
	input  wire logic [bls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bls_pkg::CFG_W-1:0]     cfg_data,
	output int                                 failures,
	output int                                 outstanding
);

	logic [bls_pkg::CFG_W-1:0]   cycle_cfg;
	logic [bls_pkg::CFG_W-1:0]   blink_cfg;
	logic [1:0]                  mode_q;
	logic [1:0]                  step_q;
	logic [bls_pkg::TIMER_W-1:0] show_ms;
	logic [bls_pkg::TIMER_W-1:0] blink_ms;
	logic [1:0]                  color_q;
	logic                        blink_q;
	logic [bls_pkg::TIMER_W-1:0] glow_q;
	logic                        lit_q;
	logic                        red_q;
	logic                        green_q;

	bls_pkg::result_t expected_leds[$];
	int errors = 0;

	task automatic advance_tick(input bls_pkg::item_t w, output bls_pkg::result_t r);
		if (show_ms != bls_pkg::TIMER_MAX) show_ms++;
		if (blink_ms != bls_pkg::TIMER_MAX) blink_ms++;
		case (mode_q)
			bls_pkg::MODE_STARTUP: begin
				if (w.startup_complete) begin
					mode_q = bls_pkg::MODE_IDLE;
					red_q = 1'b0;
					green_q = 1'b0;
				end else if (show_ms >= cycle_cfg) begin
					step_q = (step_q >= bls_pkg::STEP_GREEN) ? bls_pkg::STEP_RED
					                                         : step_q + 2'd1;
					red_q = (step_q != bls_pkg::STEP_GREEN);
					green_q = (step_q != bls_pkg::STEP_RED);
					show_ms = '0;
				end
			end
			bls_pkg::MODE_SHOW: begin
				if (w.turn_off ||
				    (glow_q != bls_pkg::GLOW_ENDLESS && show_ms >= glow_q)) begin
					mode_q = bls_pkg::MODE_IDLE;
					red_q = 1'b0;
					green_q = 1'b0;
				end else begin
					if (lit_q) begin
						case (color_q)
							bls_pkg::COLOR_RED: begin
								red_q = 1'b1;
								green_q = 1'b0;
							end
							bls_pkg::COLOR_YELLOW: begin
								red_q = 1'b1;
								green_q = 1'b1;
							end
							bls_pkg::COLOR_GREEN: begin
								red_q = 1'b0;
								green_q = 1'b1;
							end
							// color none keeps the leds as they are
							default: ;
						endcase
					end else begin
						red_q = 1'b0;
						green_q = 1'b0;
					end
					if (blink_q && blink_ms >= blink_cfg) begin
						lit_q = ~lit_q;
						blink_ms = '0;
					end
				end
			end
			default: begin
				// startup run has priority over a show request
				if (w.startup_run) begin
					mode_q = bls_pkg::MODE_STARTUP;
					show_ms = '0;
				end else if (w.show_request) begin
					color_q = w.req_color;
					blink_q = w.req_blink;
					glow_q = w.req_glow_ms;
					lit_q = 1'b1;
					mode_q = bls_pkg::MODE_SHOW;
					show_ms = '0;
					blink_ms = '0;
				end
			end
		endcase
		r.red_on = red_q;
		r.green_on = green_q;
		r.mode_now = mode_q;
	endtask

	task automatic compare_field(input string name, input logic [1:0] want,
		input logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bls_pkg::result_t want;
		if (!arst_n) begin
			cycle_cfg = bls_pkg::CYCLE_PERIOD_RESET;
			blink_cfg = bls_pkg::BLINK_HALF_RESET;
			mode_q = bls_pkg::MODE_IDLE;
			step_q = '0;
			show_ms = '0;
			blink_ms = '0;
			color_q = bls_pkg::COLOR_RED;
			blink_q = 1'b0;
			glow_q = '0;
			lit_q = 1'b0;
			red_q = 1'b0;
			green_q = 1'b0;
			expected_leds.delete();
			failures <= errors;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bls_pkg::CFG_CYCLE_PERIOD) cycle_cfg = cfg_data;
				else if (cfg_index == bls_pkg::CFG_BLINK_HALF) blink_cfg = cfg_data;
			end
			if (result_valid && !result_stall) begin
				if (expected_leds.size() == 0) begin
					$display("%0t: result word with nothing expected, expected none, got %0d/%0d/%0d",
						$time, result.red_on, result.green_on, result.mode_now);
					errors++;
				end else begin
					want = expected_leds.pop_front();
					compare_field("red_on", {1'b0, want.red_on}, {1'b0, result.red_on});
					compare_field("green_on", {1'b0, want.green_on}, {1'b0, result.green_on});
					compare_field("mode_now", want.mode_now, result.mode_now);
				end
			end
			if (item_valid && !item_stall) begin
				advance_tick(item, want);
				expected_leds.push_back(want);
			end
			failures <= errors;
			outstanding <= expected_leds.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives tick words and register writes into bicolor_led_sequencer,
// stalls the result side at random and gives the verdict; needs bls_pkg, bls_scoreboard
module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int ITEM_W         = $bits(bls_pkg::item_t);

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	bls_pkg::item_t                item = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	bls_pkg::result_t              result;
	logic                          cfg_we = 1'b0;
	logic [bls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bls_pkg::CFG_W-1:0]     cfg_data = '0;

	logic calm = 1'b0;
	int   failures;
	int   outstanding;
	int   quiet_cycles = 0;
	int   words_sent = 0;

	always #5 clk = ~clk;

	bicolor_led_sequencer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bls_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		result_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
	end

	// ends the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bls_pkg::item_t make_word(input int run, input int done, input int req,
		input int off, input logic [1:0] color, input int blink, input logic [15:0] glow);
		bls_pkg::item_t w;
		w.startup_run = run[0];
		w.startup_complete = done[0];
		w.show_request = req[0];
		w.turn_off = off[0];
		w.req_color = color;
		w.req_blink = blink[0];
		w.req_glow_ms = glow;
		return w;
	endfunction

	function automatic bls_pkg::item_t random_word();
		bls_pkg::item_t w;
		w = bls_pkg::item_t'(ITEM_W'($urandom));
		return w;
	endfunction

	// mostly short glow times so shows expire inside a sequence
	function automatic logic [15:0] pick_glow();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) return 16'($urandom_range(0, 40));
		else if (sel == 6) return bls_pkg::GLOW_ENDLESS;
		else if (sel == 7) return 16'd0;
		else return 16'($urandom);
	endfunction

	task automatic send_word(input bls_pkg::item_t w);
		if (!calm && $urandom_range(99) < 29) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [bls_pkg::CFG_W-1:0] cycle_ms,
		input logic [bls_pkg::CFG_W-1:0] half_ms);
		cfg_we <= 1'b1;
		cfg_index <= bls_pkg::CFG_CYCLE_PERIOD;
		cfg_data <= cycle_ms;
		@(posedge clk);
		cfg_index <= bls_pkg::CFG_BLINK_HALF;
		cfg_data <= half_ms;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic startup_sequence();
		bls_pkg::item_t w;
		int n;
		w = random_word();
		w.startup_run = 1'b1;
		send_word(w);
		n = $urandom_range(0, 60);
		repeat (n) begin
			w = random_word();
			w.startup_complete = 1'b0;
			send_word(w);
		end
		if ($urandom_range(7) != 0) begin
			w = random_word();
			w.startup_complete = 1'b1;
			send_word(w);
		end
	endtask

	task automatic color_sequence();
		bls_pkg::item_t w;
		int n;
		w = random_word();
		w.startup_run = 1'b0;
		w.show_request = 1'b1;
		w.req_glow_ms = pick_glow();
		send_word(w);
		n = $urandom_range(0, 40);
		repeat (n) begin
			w = random_word();
			w.turn_off = 1'b0;
			send_word(w);
		end
		if ($urandom_range(3) != 0) begin
			w = random_word();
			w.turn_off = 1'b1;
			send_word(w);
		end
	endtask

	task automatic run_phase(input logic [bls_pkg::CFG_W-1:0] cycle_ms,
		input logic [bls_pkg::CFG_W-1:0] half_ms, input int budget);
		bls_pkg::item_t w;
		int stop_at;
		int sel;
		write_settings(cycle_ms, half_ms);
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			sel = $urandom_range(19);
			if (sel < 9) startup_sequence();
			else if (sel < 18) color_sequence();
			else repeat ($urandom_range(1, 4)) send_word(random_word());
		end
		// bring the block back to idle whatever mode it ended in
		w = random_word();
		w.startup_run = 1'b0;
		w.show_request = 1'b0;
		w.startup_complete = 1'b1;
		w.turn_off = 1'b1;
		send_word(w);
		drain();
	endtask

	task automatic directed_words();
		send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		// flags out of place in idle
		send_word(make_word(0, 1, 0, 1, bls_pkg::COLOR_GREEN, 1, bls_pkg::GLOW_ENDLESS));
		send_word(make_word(1, 0, 1, 0, bls_pkg::COLOR_YELLOW, 0, 16'd10));
		send_word(make_word(0, 0, 1, 1, bls_pkg::COLOR_RED, 1, 16'd0));
		send_word(make_word(1, 0, 0, 0, bls_pkg::COLOR_NONE, 0, 16'd0));
		send_word(make_word(0, 1, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 1, 0, bls_pkg::COLOR_NONE, 0, 16'd3));
		repeat (3) send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		// zero glow ends at the first tick
		send_word(make_word(0, 0, 1, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 1, 0, bls_pkg::COLOR_YELLOW, 1, bls_pkg::GLOW_ENDLESS));
		send_word(make_word(1, 1, 1, 0, bls_pkg::COLOR_GREEN, 0, 16'd5));
		send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 0, 1, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 1, 1, bls_pkg::COLOR_GREEN, 0, 16'd1));
		send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(1, 1, 1, 1, bls_pkg::COLOR_NONE, 1, bls_pkg::GLOW_ENDLESS));
		send_word(make_word(0, 1, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 1, 0, bls_pkg::COLOR_GREEN, 1, 16'hFFFE));
		send_word(make_word(0, 0, 0, 0, bls_pkg::COLOR_RED, 0, 16'd0));
		send_word(make_word(0, 0, 0, 1, bls_pkg::COLOR_RED, 0, 16'd0));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		drain();
		run_phase(16'd1, 16'd1, 180);
		calm <= 1'b1;
		run_phase(16'd3, 16'd2, 230);
		calm <= 1'b0;
		run_phase(16'hFFFF, 16'hFFFF, 90);
		run_phase(16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)), 230);
		run_phase(16'($urandom_range(10, 80)), 16'($urandom_range(5, 40)), 230);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
